// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Transaction payloads, operation and status codes, and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int VALUE_W = 31;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_PEEK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] result_value;
		logic [1:0]         status;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       capture;
		logic       commit;
		logic       do_insert;
		logic       do_remove;
		logic       take_head;
		logic [1:0] status;
	} spq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       empty;
		logic       full;
	} spq_stat_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl: transaction controller
// Accepts one request, decodes it against the queue state and commits it
// once the response register is free.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	input  spq_stat_t stat,
	output spq_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.capture   = req_valid && (state_q == S_IDLE);
		cmd.commit    = (state_q == S_EXEC) && slot_free;
		cmd.status    = ST_OK;
		case (stat.op)
			OP_INSERT: begin
				cmd.status    = stat.full ? ST_FULL : ST_OK;
				cmd.do_insert = !stat.full;
			end
			OP_REMOVE: begin
				cmd.status    = stat.empty ? ST_EMPTY : ST_OK;
				cmd.do_remove = !stat.empty;
				cmd.take_head = !stat.empty;
			end
			OP_PEEK: begin
				cmd.status    = stat.empty ? ST_EMPTY : ST_OK;
				cmd.take_head = !stat.empty;
			end
			default: begin
				cmd.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/spq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath: sorted store and response register
// A row of cells kept in descending order; every cell picks its next value
// from itself, its upper neighbor or the new value; on remove, the lower one.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_t      req,
	input  spq_cmd_t  cmd,
	output spq_stat_t stat,
	output rsp_t      rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [1:0]         op_q;
	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   count_q;
	logic [VALUE_W-1:0] entries_q [CAPACITY];
	logic [VALUE_W-1:0] ins_next [CAPACITY];
	logic [VALUE_W-1:0] rem_next [CAPACITY];
	logic [CAPACITY-1:0] gt;
	rsp_t               rsp_q;

	assign stat.op    = op_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(CAPACITY));
	assign rsp        = rsp_q;

	// gt[k]: cell k holds a stored value strictly above the new one
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		assign gt[k] = (CNT_W'(k) < count_q) && (entries_q[k] > value_q);
		if (k == 0) begin : g_head
			assign ins_next[k] = gt[k] ? entries_q[k] : value_q;
		end else begin : g_body
			assign ins_next[k] = gt[k] ? entries_q[k] :
				(gt[k-1] ? value_q : entries_q[k-1]);
		end
		if (k == CAPACITY - 1) begin : g_tail
			assign rem_next[k] = entries_q[k];
		end else begin : g_mid
			assign rem_next[k] = entries_q[k+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.commit && cmd.do_insert) begin
				entries_q[k] <= ins_next[k];
			end else if (cmd.commit && cmd.do_remove) begin
				entries_q[k] <= rem_next[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= req.op;
			value_q <= req.value;
		end
		if (cmd.commit) begin
			rsp_q.result_value <= cmd.take_head ? entries_q[0] : '0;
			rsp_q.status       <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit && cmd.do_insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.commit && cmd.do_remove) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in descending order
// Each request inserts a value, removes the largest or peeks at it, and
// returns one response with the value and a status code.
// ----------------------------------------------------------------------------
// Every request is first captured and then committed; in the commit the
// whole row of cells shifts in parallel (insert or remove) and the response
// register loads. A new request is taken as soon as the previous one has
// committed, even while its response is still stalled downstream; a commit
// waits only when the response register is full and stalled. Values are
// non-negative; among equal values the newest leaves first. Remove or peek on
// an empty queue returns status 1 and value 0; an insert into a full queue is
// dropped with status 2. Op code 3 does nothing and returns status 0. No
// clearing pass follows reset: the queue is empty as soon as arst_n is high.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	spq_cmd_t  cmd;
	spq_stat_t stat;

	// control: handshake, decode, commit timing
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage: sorted cells, fill count, response payload
	spq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the request and response channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// hold a stalled request
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request changed or dropped");

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed or dropped");

	// drop the value on any error
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> rsp.result_value == '0)
		else $error("error response carries a value");

	// one transaction in flight: busy right after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one still executing");

	// a response appears only after a request was in execution
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without a request");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
